[design/lmq_pkg.sv]
// Shared types and codes for the linked multi-queue core.
package lmq_pkg;

   // Operation codes carried from the front to the back end
   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_MOVE   = 2'd1,
      OP_LIST   = 2'd2
   } op_type;

   // Request mode code that is dropped on entry
   localparam logic [1:0] MODE_NONE = 2'd3;

   // Response status codes
   localparam logic [1:0] ST_ENTRY = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_DROP  = 2'd2;

   // Width of a station number on the request port
   localparam int STN_W = 10;

endpackage

[design/lmq_front.sv]
// Front end: takes a request word, folds station numbers into range, classifies it.
module lmq_front
   import lmq_pkg::*;
#(
   parameter int QUEUE_COUNT = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            front_busy,
   input  logic [1:0]                      req_mode,
   input  logic signed [31:0]              req_train_value,
   input  logic [STN_W-1:0]                req_source_station,
   input  logic [STN_W-1:0]                req_dest_station,
   input  logic                            fifo_full,
   output logic                            push,
   output op_type                          push_op,
   output logic [31:0]                     push_value,
   output logic [$clog2(QUEUE_COUNT)-1:0]  push_src,
   output logic [$clog2(QUEUE_COUNT)-1:0]  push_dst
);

   localparam int QW = $clog2(QUEUE_COUNT);

   // Number of shifted compare-subtract levels that bring a station below QUEUE_COUNT
   function automatic int red_levels();
      int k;
      k = 0;
      while ((QUEUE_COUNT << k) < (1 << STN_W)) begin
         k++;
      end
      return k;
   endfunction

   localparam int RED_LEVELS = red_levels();
   localparam int LW = (RED_LEVELS > 0) ? $clog2(RED_LEVELS + 1) : 1;

   logic               fv_ff;
   logic [LW-1:0]      left_ff;
   logic [1:0]         mode_ff;
   logic [31:0]        value_ff;
   logic [STN_W-1:0]   src_ff;
   logic [STN_W-1:0]   dst_ff;

   logic [LW-1:0]      lvl;
   logic [STN_W:0]     div;
   logic [STN_W-1:0]   src_red;
   logic [STN_W-1:0]   dst_red;
   logic               reducing;
   logic               done;
   logic               keep;
   logic               release_item;
   logic [QW+STN_W-1:0] src_wide;
   logic [QW+STN_W-1:0] dst_wide;

   // One reduction level per cycle, highest multiple first
   always_comb begin
      lvl      = left_ff - LW'(1);
      div      = (STN_W + 1)'(QUEUE_COUNT << lvl);
      src_red  = ({1'b0, src_ff} >= div) ? src_ff - div[STN_W-1:0] : src_ff;
      dst_red  = ({1'b0, dst_ff} >= div) ? dst_ff - div[STN_W-1:0] : dst_ff;
      reducing = fv_ff && (left_ff != '0);
      done     = fv_ff && (left_ff == '0);
   end

   // Station numbers to table index width
   assign src_wide = {{QW{1'b0}}, src_ff};
   assign dst_wide = {{QW{1'b0}}, dst_ff};
   assign push_src = src_wide[QW-1:0];
   assign push_dst = dst_wide[QW-1:0];

   // Classify: unknown mode and a self move are dropped here
   assign keep = (mode_ff != MODE_NONE)
              && !((mode_ff == OP_MOVE) && (push_src == push_dst));
   assign push         = done && keep && !fifo_full;
   assign release_item = done && (!keep || !fifo_full);
   assign push_op      = op_type'(mode_ff);
   assign push_value   = value_ff;
   assign front_busy   = fv_ff;

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff   <= 1'b0;
         left_ff <= '0;
      end else if (start && !fv_ff) begin
         fv_ff   <= 1'b1;
         left_ff <= LW'(RED_LEVELS);
      end else if (reducing) begin
         left_ff <= lvl;
      end else if (release_item) begin
         fv_ff   <= 1'b0;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (start && !fv_ff) begin
         mode_ff  <= req_mode;
         value_ff <= req_train_value;
         src_ff   <= req_source_station;
         dst_ff   <= req_dest_station;
      end else if (reducing) begin
         src_ff   <= src_red;
         dst_ff   <= dst_red;
      end
   end

endmodule

[design/lmq_fifo.sv]
// Two-word queue between the front and back ends.
module lmq_fifo #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   input  logic         pop,
   output logic [W-1:0] head_data,
   output logic         empty,
   output logic         full
);

   logic [W-1:0] slot_ff [2];
   logic         wp_ff;
   logic         rp_ff;
   logic [1:0]   cnt_ff;

   assign empty     = (cnt_ff == 2'd0);
   assign full      = (cnt_ff == 2'd2);
   assign head_data = slot_ff[rp_ff];

   // Pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop)  rp_ff <= ~rp_ff;
         if (push && !pop)      cnt_ff <= cnt_ff + 2'd1;
         else if (pop && !push) cnt_ff <= cnt_ff - 2'd1;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) slot_ff[wp_ff] <= push_data;
   end

endmodule

[design/lmq_back.sv]
// Back end: queue table, entry pool, append/splice/list sequencer, response register.
module lmq_back
   import lmq_pkg::*;
#(
   parameter int QUEUE_COUNT  = 1024,
   parameter int POOL_ENTRIES = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            fifo_empty,
   input  op_type                          item_op,
   input  logic [31:0]                     item_value,
   input  logic [$clog2(QUEUE_COUNT)-1:0]  item_src,
   input  logic [$clog2(QUEUE_COUNT)-1:0]  item_dst,
   output logic                            pop,
   output logic                            clearing,
   output logic                            rsp_strobe,
   output logic [1:0]                      rsp_status,
   output logic signed [31:0]              rsp_entry_value,
   output logic                            rsp_last
);

   localparam int QW = $clog2(QUEUE_COUNT);
   localparam int PW = $clog2(POOL_ENTRIES);
   localparam int RW = 1 + 2 * PW;

   typedef enum logic [3:0] {
      B_IDLE = 4'b0001,
      B_EXE  = 4'b0010,
      B_MV2  = 4'b0100,
      B_WALK = 4'b1000
   } back_state_type;

   // Queue table row: {nonempty, head, tail}
   logic [RW-1:0]  qtab_mem  [QUEUE_COUNT];
   logic [31:0]    edata_mem [POOL_ENTRIES];
   logic [PW-1:0]  enext_mem [POOL_ENTRIES];

   back_state_type state_ff, state_in;
   logic           clr_ff;
   logic [QW-1:0]  clr_idx_ff;
   logic [PW:0]    used_ff, used_in;
   op_type         op_ff;
   logic [31:0]    val_ff;
   logic [QW-1:0]  src_ff;
   logic [QW-1:0]  dst_ff;
   logic [RW-1:0]  qrs_ff;
   logic [RW-1:0]  qrd_ff;
   logic [31:0]    erd_data_ff;
   logic [PW-1:0]  erd_next_ff;
   logic [PW-1:0]  cur_ff, cur_in;
   logic [PW-1:0]  tail_ff, tail_in;
   logic [PW-1:0]  n_ff, n_in;
   logic           rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]     rsp_status_ff, rsp_status_in;
   logic [31:0]    rsp_value_ff, rsp_value_in;
   logic           rsp_last_ff, rsp_last_in;

   logic           q_we;
   logic [QW-1:0]  q_waddr;
   logic [RW-1:0]  q_wdata;
   logic           d_we;
   logic           x_we;
   logic [PW-1:0]  x_waddr;
   logic [PW-1:0]  x_wdata;
   logic [PW-1:0]  e_raddr;

   logic           sne, dne, full, at_tail, final_slot;
   logic [PW-1:0]  shead, stail, dhead, dtail, e_new;

   assign sne   = qrs_ff[RW-1];
   assign shead = qrs_ff[2*PW-1:PW];
   assign stail = qrs_ff[PW-1:0];
   assign dne   = qrd_ff[RW-1];
   assign dhead = qrd_ff[2*PW-1:PW];
   assign dtail = qrd_ff[PW-1:0];
   assign full  = (used_ff == (PW + 1)'(POOL_ENTRIES));
   assign e_new = used_ff[PW-1:0];
   assign at_tail    = (cur_ff == tail_ff);
   assign final_slot = (n_ff == PW'(POOL_ENTRIES - 1));

   assign clearing        = clr_ff;
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_value = rsp_value_ff;
   assign rsp_last        = rsp_last_ff;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      cur_in        = cur_ff;
      tail_in       = tail_ff;
      n_in          = n_ff;
      pop           = 1'b0;
      q_we          = 1'b0;
      q_waddr       = dst_ff;
      q_wdata       = '0;
      d_we          = 1'b0;
      x_we          = 1'b0;
      x_waddr       = dtail;
      x_wdata       = e_new;
      e_raddr       = erd_next_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = ST_ENTRY;
      rsp_value_in  = '0;
      rsp_last_in   = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (!clr_ff && !fifo_empty) begin
               pop      = 1'b1;
               state_in = B_EXE;
            end
         end
         B_EXE: begin
            e_raddr  = dhead;
            state_in = B_IDLE;
            case (op_ff)
               OP_APPEND: begin
                  if (full) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = ST_DROP;
                     rsp_last_in   = 1'b1;
                  end else begin
                     d_we    = 1'b1;
                     x_we    = dne;
                     q_we    = 1'b1;
                     q_wdata = {1'b1, (dne ? dhead : e_new), e_new};
                     used_in = used_ff + (PW + 1)'(1);
                  end
               end
               OP_MOVE: begin
                  if (sne) begin
                     x_we     = dne;
                     x_wdata  = shead;
                     q_we     = 1'b1;
                     q_wdata  = {1'b1, (dne ? dhead : shead), stail};
                     state_in = B_MV2;
                  end
               end
               OP_LIST: begin
                  if (!dne) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = ST_EMPTY;
                     rsp_last_in   = 1'b1;
                  end else begin
                     cur_in   = dhead;
                     tail_in  = dtail;
                     n_in     = '0;
                     state_in = B_WALK;
                  end
               end
               default: begin
                  state_in = B_IDLE;
               end
            endcase
         end
         B_MV2: begin
            // source queue becomes empty
            q_we     = 1'b1;
            q_waddr  = src_ff;
            q_wdata  = {1'b0, shead, stail};
            state_in = B_IDLE;
         end
         B_WALK: begin
            rsp_strobe_in = 1'b1;
            rsp_status_in = ST_ENTRY;
            rsp_value_in  = erd_data_ff;
            rsp_last_in   = at_tail || final_slot;
            cur_in        = erd_next_ff;
            n_in          = n_ff + PW'(1);
            if (at_tail || final_slot) state_in = B_IDLE;
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // Control registers and clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         clr_ff        <= 1'b1;
         clr_idx_ff    <= '0;
         used_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (clr_ff) begin
            if (clr_idx_ff == QW'(QUEUE_COUNT - 1)) clr_ff <= 1'b0;
            else clr_idx_ff <= clr_idx_ff + QW'(1);
         end
      end
   end

   // Item and walk payload, response payload
   always_ff @(posedge clock) begin
      if (pop) begin
         op_ff  <= item_op;
         val_ff <= item_value;
         src_ff <= item_src;
         dst_ff <= item_dst;
      end
      cur_ff        <= cur_in;
      tail_ff       <= tail_in;
      n_ff          <= n_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Queue table: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (clr_ff) qtab_mem[clr_idx_ff] <= '0;
      else if (q_we) qtab_mem[q_waddr] <= q_wdata;
      qrs_ff <= qtab_mem[item_src];
      qrd_ff <= qtab_mem[item_dst];
   end

   // Entry pool: data and next-link memories
   always_ff @(posedge clock) begin
      if (d_we) edata_mem[e_new] <= val_ff;
      if (x_we) enext_mem[x_waddr] <= x_wdata;
      erd_data_ff <= edata_mem[e_raddr];
      erd_next_ff <= enext_mem[e_raddr];
   end

endmodule

[design/linked_multi_queue_append_splice_core.sv]
// Top level of the linked multi-queue core: front end, word queue, back end.
//
// A bank of QUEUE_COUNT FIFO queues kept as linked lists in a pool of
// POOL_ENTRIES entries. After reset the queue table is cleared one row per
// cycle, and busy stays high until the pass is done. A word is accepted
// when start is high and busy is low; the front end then holds it, folding
// the station numbers level by level when QUEUE_COUNT is below 1024, and
// keeps busy high, taking no new word, until it is passed to a two-word
// queue or dropped. The back end reads the queue table as it takes a word
// and writes it in the next cycle; a splice writes the destination row and
// then, in state B_MV2, the source row (both go through the single table
// write port). A list is walked one entry per cycle from the pool memory.
// Results come out on rsp_strobe for exactly one cycle each and cannot be
// held off; rsp_last marks the final result of a word. A successful append
// and a splice give no result.
module linked_multi_queue_append_splice_core
   import lmq_pkg::*;
#(
   parameter int QUEUE_COUNT  = 1024,
   parameter int POOL_ENTRIES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_mode,
   input  logic signed [31:0] req_train_value,
   input  logic [9:0]         req_source_station,
   input  logic [9:0]         req_dest_station,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_entry_value,
   output logic               rsp_last
);

   localparam int QW = $clog2(QUEUE_COUNT);
   localparam int FW = 2 + 32 + 2 * QW;

   logic           front_busy;
   logic           clearing;
   logic           push;
   op_type         push_op;
   logic [31:0]    push_value;
   logic [QW-1:0]  push_src;
   logic [QW-1:0]  push_dst;
   logic           fifo_full;
   logic           fifo_empty;
   logic           pop;
   logic [FW-1:0]  head_data;

   assign busy = clearing || front_busy;

   lmq_front #(
      .QUEUE_COUNT(QUEUE_COUNT)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .start              (start && !clearing),
      .front_busy         (front_busy),
      .req_mode           (req_mode),
      .req_train_value    (req_train_value),
      .req_source_station (req_source_station),
      .req_dest_station   (req_dest_station),
      .fifo_full          (fifo_full),
      .push               (push),
      .push_op            (push_op),
      .push_value         (push_value),
      .push_src           (push_src),
      .push_dst           (push_dst)
   );

   lmq_fifo #(
      .W(FW)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_op, push_value, push_src, push_dst}),
      .pop       (pop),
      .head_data (head_data),
      .empty     (fifo_empty),
      .full      (fifo_full)
   );

   lmq_back #(
      .QUEUE_COUNT (QUEUE_COUNT),
      .POOL_ENTRIES(POOL_ENTRIES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .fifo_empty      (fifo_empty),
      .item_op         (op_type'(head_data[FW-1:FW-2])),
      .item_value      (head_data[FW-3:2*QW]),
      .item_src        (head_data[2*QW-1:QW]),
      .item_dst        (head_data[QW-1:0]),
      .pop             (pop),
      .clearing        (clearing),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_entry_value (rsp_entry_value),
      .rsp_last        (rsp_last)
   );

   // The table clearing pass holds off requests right after reset
   a_reset_busy: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   // Empty and drop responses are single words
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != ST_ENTRY) |-> rsp_last)
      else $error("non-entry response without last");

   // Only listed entries carry a value
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != ST_ENTRY) |-> (rsp_entry_value == 32'sd0))
      else $error("non-entry response with nonzero value");

   // A list walk emits one entry every cycle until its last
   a_walk_cont: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |=> (rsp_strobe && rsp_status == ST_ENTRY))
      else $error("list walk broke off before last");

endmodule
